// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the decimal float multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/dfm_pkg.sv =====
// Package of the decimal float multiplier: constants and control types.
`timescale 1ns / 1ps
package dfm_pkg;

	localparam int DIGITS_DEFAULT = 30;

	// x / 10 == (x * RECIP_10) >> RECIP_SHIFT for x below 16384
	localparam int RECIP_10    = 6554;
	localparam int RECIP_SHIFT = 16;

	localparam logic signed [19:0] EXP_MIN = -20'sd262144;
	localparam logic signed [19:0] EXP_MAX = 20'sd262143;

	typedef struct packed {
		logic load;
		logic init;
		logic mul;
		logic div;
		logic fin;
		logic pre;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic few_cols;
		logic term_last;
		logic col_last;
		logic emit_last;
	} status_t;

endpackage

// ===== sv/dfm_ram.sv =====
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module dfm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 30
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/dfm_controller.sv =====
// Controller state machine of the decimal float multiplier.
`timescale 1ns / 1ps
module dfm_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  logic             last_digit,
	input  dfm_pkg::status_t sts,
	output dfm_pkg::cmd_t    cmd,
	output logic             busy
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_INIT, ST_MUL, ST_DIV, ST_FIN, ST_PRE, ST_EMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start && mode && last_digit) state_d = ST_INIT;
			ST_INIT: state_d = sts.few_cols ? ST_FIN : ST_MUL;
			ST_MUL:  if (sts.term_last) state_d = ST_DIV;
			ST_DIV:  state_d = sts.col_last ? ST_FIN : ST_MUL;
			ST_FIN:  state_d = ST_PRE;
			ST_PRE:  state_d = ST_EMIT;
			ST_EMIT: if (sts.emit_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != ST_IDLE);
		end
	end

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.init = (state_q == ST_INIT);
		cmd.mul  = (state_q == ST_MUL);
		cmd.div  = (state_q == ST_DIV);
		cmd.fin  = (state_q == ST_FIN);
		cmd.pre  = (state_q == ST_PRE);
		cmd.emit = (state_q == ST_EMIT);
	end

endmodule

// ===== sv/dfm_datapath.sv =====
// Datapath of the decimal float multiplier: operand store, column MAC, carry, output.
`timescale 1ns / 1ps
module dfm_datapath #(
	parameter int DIGITS = dfm_pkg::DIGITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dfm_pkg::cmd_t       cmd,
	output dfm_pkg::status_t    sts,
	input  logic                mode,
	input  logic [3:0]          digit,
	input  logic                negative,
	input  logic signed [17:0]  exponent,
	input  logic                last_digit,
	output logic                result_valid,
	output logic [3:0]          digit_res,
	output logic [5:0]          position,
	output logic                negative_res,
	output logic signed [18:0]  exponent_res,
	output logic [6:0]          digit_count,
	output logic                last
);

	localparam int CW    = $clog2(DIGITS + 1);
	localparam int AW    = $clog2(DIGITS);
	localparam int NW    = $clog2(2 * DIGITS + 1);
	localparam int ACC_W = $clog2(DIGITS * 90 + 1);
	localparam int MW    = ACC_W + 13;

	logic [3:0] left_q  [DIGITS];
	logic [3:0] right_q [DIGITS];

	logic [CW-1:0] lcnt_q, rcnt_q, lz_q, rz_q;
	logic          lseen_q, rseen_q;
	logic          lneg_q, rneg_q;
	logic signed [17:0] lexp_q, rexp_q;

	logic [CW-1:0]  la_q, ra_q, s_q, z_q, i_q, c_q, k_q;
	logic [NW-1:0]  col_q;
	logic [ACC_W-1:0] acc_q, carry_q;
	logic signed [19:0] epart_q;
	logic signed [18:0] exp_q;

	logic [3:0]  d_sat;
	logic        keep;
	logic [CW-1:0] la_c, ra_c;
	logic [NW-1:0] n_c;

	logic [NW-1:0] cm1, jj;
	logic          term_ok;
	logic [CW-1:0] lidx;
	logic [NW-1:0] ridx;
	logic [7:0]    prod;

	logic [ACC_W-1:0] total;
	logic [MW-1:0]    qmul;
	logic [ACC_W-1:0] quo;
	logic [ACC_W-1:0] rem_w;
	logic [3:0]       rem;
	logic             col_in;

	logic signed [19:0] e_c;
	logic [CW:0]        rd_next;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [3:0]    wdata, rdata;

	assign d_sat = (digit > 4'd9) ? 4'd9 : digit;
	assign keep  = mode ? (rcnt_q < CW'(DIGITS)) : (lcnt_q < CW'(DIGITS));

	assign la_c = lcnt_q - lz_q;
	assign ra_c = rcnt_q - rz_q;
	assign n_c  = NW'(la_c) + NW'(ra_c);

	// one digit pair of column col_q per cycle
	assign cm1     = col_q - NW'(1);
	assign jj      = cm1 - NW'(i_q);
	assign term_ok = (i_q < la_q) && (cm1 >= NW'(i_q)) && (jj < NW'(ra_q));
	assign lidx    = lz_q + i_q;
	assign ridx    = NW'(rz_q) + jj;
	assign prod    = term_ok ? (8'(left_q[lidx[AW-1:0]]) * 8'(right_q[ridx[AW-1:0]])) : 8'd0;

	// column close: digit and carry by reciprocal of ten
	assign total  = acc_q + carry_q;
	assign qmul   = MW'(total) * MW'(dfm_pkg::RECIP_10);
	assign quo    = ACC_W'(qmul >> dfm_pkg::RECIP_SHIFT);
	assign rem_w  = total - ACC_W'((quo << 3) + (quo << 1));
	assign rem    = rem_w[3:0];
	assign col_in = (col_q < NW'(s_q));

	assign e_c = epart_q - 20'(z_q);

	assign sts.few_cols  = (n_c < NW'(2));
	assign sts.term_last = ({1'b0, i_q} + (CW+1)'(1)) >= {1'b0, la_q};
	assign sts.col_last  = (col_q == NW'(1));
	assign sts.emit_last = (c_q == '0) || ({1'b0, k_q} + (CW+1)'(1) == {1'b0, c_q});

	assign rd_next = {1'b0, z_q} + {1'b0, k_q} + (CW+1)'(1);
	assign raddr   = cmd.pre ? z_q[AW-1:0] :
		((rd_next < (CW+1)'(DIGITS)) ? rd_next[AW-1:0] : '0);
	assign we      = (cmd.div && col_in) || cmd.fin;
	assign waddr   = cmd.fin ? '0 : col_q[AW-1:0];
	assign wdata   = cmd.fin ? carry_q[3:0] : rem;

	dfm_ram #(.WIDTH(4), .DEPTH(DIGITS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// operand digit store
	always_ff @(posedge clk) begin
		if (cmd.load && keep) begin
			if (mode) begin
				right_q[rcnt_q[AW-1:0]] <= d_sat;
			end else begin
				left_q[lcnt_q[AW-1:0]] <= d_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q  <= '0;
			rcnt_q  <= '0;
			lz_q    <= '0;
			rz_q    <= '0;
			lseen_q <= 1'b0;
			rseen_q <= 1'b0;
			lneg_q  <= 1'b0;
			rneg_q  <= 1'b0;
			lexp_q  <= '0;
			rexp_q  <= '0;
		end else if (cmd.load) begin
			if (mode) begin
				if (keep) begin
					rcnt_q <= rcnt_q + CW'(1);
					if (d_sat == 4'd0 && !rseen_q) rz_q <= rz_q + CW'(1);
					if (d_sat != 4'd0) rseen_q <= 1'b1;
				end
				if (last_digit) begin
					rneg_q <= negative;
					rexp_q <= exponent;
				end
			end else begin
				if (keep) begin
					lcnt_q <= lcnt_q + CW'(1);
					if (d_sat == 4'd0 && !lseen_q) lz_q <= lz_q + CW'(1);
					if (d_sat != 4'd0) lseen_q <= 1'b1;
				end
				if (last_digit) begin
					lneg_q <= negative;
					lexp_q <= exponent;
				end
			end
		end else if (cmd.fin) begin
			lcnt_q  <= '0;
			rcnt_q  <= '0;
			lz_q    <= '0;
			rz_q    <= '0;
			lseen_q <= 1'b0;
			rseen_q <= 1'b0;
		end
	end

	// product sequencing registers
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			la_q    <= la_c;
			ra_q    <= ra_c;
			s_q     <= (n_c < NW'(DIGITS)) ? CW'(n_c) : CW'(DIGITS);
			z_q     <= (n_c < NW'(DIGITS)) ? CW'(n_c) : CW'(DIGITS);
			col_q   <= n_c - NW'(1);
			i_q     <= '0;
			acc_q   <= '0;
			carry_q <= '0;
			epart_q <= 20'(lexp_q) + 20'(rexp_q) - 20'(lz_q) - 20'(rz_q);
		end else if (cmd.mul) begin
			acc_q <= acc_q + ACC_W'(prod);
			i_q   <= i_q + CW'(1);
		end else if (cmd.div) begin
			if (col_in && rem != 4'd0) z_q <= CW'(col_q);
			carry_q <= quo;
			acc_q   <= '0;
			i_q     <= '0;
			col_q   <= col_q - NW'(1);
		end else if (cmd.fin) begin
			if (carry_q != '0 && s_q != '0) z_q <= '0;
		end else if (cmd.pre) begin
			c_q <= s_q - z_q;
			k_q <= '0;
			if (e_c < dfm_pkg::EXP_MIN) exp_q <= 19'(dfm_pkg::EXP_MIN);
			else if (e_c > dfm_pkg::EXP_MAX) exp_q <= 19'(dfm_pkg::EXP_MAX);
			else exp_q <= 19'(e_c);
		end else if (cmd.emit) begin
			k_q <= k_q + CW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			negative_res <= lneg_q ^ rneg_q;
			if (c_q == '0) begin
				digit_res    <= 4'd0;
				position     <= 6'd0;
				exponent_res <= '0;
				digit_count  <= 7'd0;
				last         <= 1'b1;
			end else begin
				digit_res    <= rdata;
				position     <= 6'(k_q);
				exponent_res <= exp_q;
				digit_count  <= 7'(c_q);
				last         <= sts.emit_last;
			end
		end
	end

endmodule

// ===== sv/decimal_float_multiplier.sv =====
// Top level of the decimal float multiplier: controller plus datapath.
//
// Usage: one operand digit is transferred per cycle on start while busy is low,
// tagged by mode (0 left, 1 right), most significant digit first. The transfer
// carrying last_digit also carries the operand's sign and exponent. Digits past
// DIGITS per operand are dropped. A right operand's last digit starts the
// product and raises busy the next cycle.
// Compute: the product is formed column by column, least significant first,
// one digit pair per cycle through a single 4x4 multiplier and accumulator,
// then a separate step per column splits digit and carry (reciprocal of ten).
// Sequence: INIT, the column loop (MUL over the pairs, DIV per column), FIN,
// PRE, then EMIT; the loop is skipped when la + ra significant digits < 2.
// Busy stays high through the result digits and drops with the final one,
// so the next digit can transfer at the edge that ends it.
// Results: one digit per cycle, marked by result_valid for exactly one cycle,
// the final one with last. A zero product gives a single item. Result digits
// are read from a DIGITS-deep RAM with registered read.
// The receiver cannot stall; results are never held back or repeated.
// Reset (arst_n low) clears counts, latched signs and exponents, and control.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module decimal_float_multiplier #(
	parameter int DIGITS = dfm_pkg::DIGITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [3:0]         digit,
	input  logic               negative,
	input  logic signed [17:0] exponent,
	input  logic               last_digit,
	output logic               result_valid,
	output logic [3:0]         digit_res,
	output logic [5:0]         position,
	output logic               negative_res,
	output logic signed [18:0] exponent_res,
	output logic [6:0]         digit_count,
	output logic               last
);

	dfm_pkg::cmd_t    cmd;
	dfm_pkg::status_t sts;

	// sequencing: load, init, column MAC / carry loop, finish, prepare, emit
	dfm_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.last_digit (last_digit),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	dfm_datapath #(.DIGITS(DIGITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.digit        (digit),
		.negative     (negative),
		.exponent     (exponent),
		.last_digit   (last_digit),
		.result_valid (result_valid),
		.digit_res    (digit_res),
		.position     (position),
		.negative_res (negative_res),
		.exponent_res (exponent_res),
		.digit_count  (digit_count),
		.last         (last)
	);

	// a product's digits leave in consecutive cycles
	`ASSERT_NEXT(a_burst, clk, arst_n, result_valid && !last, result_valid)
	// nothing follows the final digit directly
	`ASSERT_NEXT(a_gap, clk, arst_n, result_valid && last, !result_valid)
	// the closing right digit starts the product
	`ASSERT_NEXT(a_go, clk, arst_n, start && !busy && mode && last_digit, busy)
	// result digits are decimal
	`ASSERT_SAME(a_dec, clk, arst_n, result_valid, digit_res <= 4'd9)

endmodule
